// File: sv/wlan_channel_scan_sequencer_core_macros.svh
`ifndef WLAN_CHANNEL_SCAN_SEQUENCER_CORE_MACROS_SVH
`define WLAN_CHANNEL_SCAN_SEQUENCER_CORE_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define WCSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define WCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/wcss_pkg.sv
package wcss_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int TIME_WIDTH_DEF   = 48;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_START   = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_ABORT   = 2'd3
    } wcss_req_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_TUNE   = 3'd1,
        ACT_ARM    = 3'd2,
        ACT_PROBE  = 3'd3,
        ACT_DONE   = 3'd4,
        ACT_REJECT = 3'd5
    } wcss_action_t;

    typedef enum logic [1:0] {
        RC_OK            = 2'd0,
        RC_NOT_SUPPORTED = 2'd1,
        RC_BUSY          = 2'd2,
        RC_INVALID       = 2'd3
    } wcss_code_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_ACTIVE_SCAN    = 3'd0,
        REG_MIN_DWELL_TU   = 3'd1,
        REG_MAX_DWELL_TU   = 3'd2,
        REG_PROBE_DELAY_TU = 3'd3,
        REG_CHANNEL_COUNT  = 3'd4
    } wcss_reg_idx_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] now_us;
        logic [5:0]  entry_slot;
        logic [7:0]  entry_channel;
    } wcss_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tune_channel;
        logic [47:0] deadline_us;
        logic [1:0]  status;
    } wcss_out_t;

endpackage

// File: sv/wcss_ram.sv
module wcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/wlan_channel_scan_sequencer_core.sv
// Channel scan sequencer: steps a passive or active 802.11-style scan across a
// list of up to MAX_CHANNELS channels held in a single-port-write, one-read
// channel table RAM. Load words fill the table while idle; a start word checks
// the request and tunes to the first channel; each timeout word, carrying the
// current microsecond time, moves to the next channel, ends the scan after the
// last one, arms the maximum dwell deadline, in active mode asks for a probe and
// arms the minimum dwell deadline, or does nothing; an abort word ends the scan
// as not supported. One time unit is 1024 us and all time arithmetic wraps at
// 2^TIME_WIDTH. The block takes one word every cycle unless a stalled output
// holds it back, and each word gives exactly one result word: the first stage
// makes the scan decision and issues the table read, the second adds the dwell
// to the base time while the table data arrives, and the result register holds
// the word until it is taken. Configuration writes are dropped while a scan runs.
`include "wlan_channel_scan_sequencer_core_macros.svh"

module wlan_channel_scan_sequencer_core #(
    parameter int MAX_CHANNELS = wcss_pkg::MAX_CHANNELS_DEF,
    parameter int TIME_WIDTH   = wcss_pkg::TIME_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              req_valid,
    output logic              req_stall,
    input  wcss_pkg::wcss_in_t  req,

    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wcss_pkg::wcss_out_t rsp,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import wcss_pkg::*;

    localparam int TW    = TIME_WIDTH;
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int POS_W = $clog2(MAX_CHANNELS + 1);
    localparam int LEN_W = (POS_W > 7) ? POS_W : 7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        active_scan_reg;
    logic [15:0] min_dwell_tu_reg;
    logic [15:0] max_dwell_tu_reg;
    logic [15:0] probe_delay_tu_reg;
    logic [6:0]  channel_count_reg;

    logic        scanning_reg;
    logic        cfg_write;
    logic [2:0]  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    // hold the registers for the whole scan
    assign cfg_write = psel && penable && pwrite && !scanning_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_scan_reg    <= 1'b0;
            min_dwell_tu_reg   <= '0;
            max_dwell_tu_reg   <= '0;
            probe_delay_tu_reg <= '0;
            channel_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ACTIVE_SCAN:    active_scan_reg    <= pwdata[0];
                REG_MIN_DWELL_TU:   min_dwell_tu_reg   <= pwdata[15:0];
                REG_MAX_DWELL_TU:   max_dwell_tu_reg   <= pwdata[15:0];
                REG_PROBE_DELAY_TU: probe_delay_tu_reg <= pwdata[15:0];
                REG_CHANNEL_COUNT:  channel_count_reg  <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ACTIVE_SCAN:    prdata = 32'(active_scan_reg);
            REG_MIN_DWELL_TU:   prdata = 32'(min_dwell_tu_reg);
            REG_MAX_DWELL_TU:   prdata = 32'(max_dwell_tu_reg);
            REG_PROBE_DELAY_TU: prdata = 32'(probe_delay_tu_reg);
            REG_CHANNEL_COUNT:  prdata = 32'(channel_count_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: decision stage, deadline stage, result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic out_load;
    logic accept;

    // load the result register when it is empty or being taken
    assign out_load  = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !out_load;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Scan state and decision stage
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [TW-1:0]    dwell_start_reg;
    logic [TW-1:0]    dwell_start_next;
    logic             scanning_next;

    logic [LEN_W-1:0] count_ext;
    logic [LEN_W-1:0] max_ext;
    logic [LEN_W-1:0] list_len;
    logic [LEN_W-1:0] pos_inc;
    logic [TW-1:0]    now_t;
    logic [TW-1:0]    elapsed;
    logic [TW-1:0]    min_us;
    logic [TW-1:0]    max_us;
    logic [TW-1:0]    probe_us;
    logic [31:0]      slot_ext;
    logic             slot_ok;

    logic             tbl_we;
    logic             tbl_re;
    logic [AW-1:0]    tbl_raddr;
    logic [7:0]       tbl_rdata;

    wcss_action_t     act_d;
    wcss_code_t       code_d;
    logic [TW-1:0]    base_d;
    logic [15:0]      tu_d;

    assign count_ext = LEN_W'(channel_count_reg);
    assign max_ext   = LEN_W'(MAX_CHANNELS);
    // an oversized count is clamped to the table depth
    assign list_len  = (count_ext > max_ext) ? max_ext : count_ext;
    assign pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);

    assign now_t     = TW'(req.now_us);
    assign elapsed   = now_t - dwell_start_reg;
    assign min_us    = TW'({min_dwell_tu_reg, 10'b0});
    assign max_us    = TW'({max_dwell_tu_reg, 10'b0});
    assign probe_us  = TW'({probe_delay_tu_reg, 10'b0});

    assign slot_ext  = 32'(req.entry_slot);
    assign slot_ok   = slot_ext < 32'(MAX_CHANNELS);

    always_comb
    begin
        scanning_next    = scanning_reg;
        pos_next         = pos_reg;
        dwell_start_next = dwell_start_reg;
        act_d            = ACT_NONE;
        code_d           = RC_OK;
        base_d           = dwell_start_reg;
        tu_d             = min_dwell_tu_reg;
        tbl_we           = 1'b0;
        tbl_re           = 1'b0;
        tbl_raddr        = '0;

        case (req.req_type)
            REQ_LOAD:
            begin
                tbl_we = accept && !scanning_reg && slot_ok;
            end
            REQ_START:
            begin
                if (scanning_reg)
                begin
                    act_d  = ACT_REJECT;
                    code_d = RC_BUSY;
                end
                else if (list_len == '0 || max_dwell_tu_reg < min_dwell_tu_reg)
                begin
                    act_d  = ACT_REJECT;
                    code_d = RC_INVALID;
                end
                else
                begin
                    scanning_next    = 1'b1;
                    pos_next         = '0;
                    dwell_start_next = now_t;
                    act_d            = ACT_TUNE;
                    base_d           = now_t;
                    tu_d             = active_scan_reg ? probe_delay_tu_reg
                                                       : min_dwell_tu_reg;
                    tbl_re           = accept;
                end
            end
            REQ_TIMEOUT:
            begin
                if (!scanning_reg)
                begin
                    act_d = ACT_NONE;
                end
                else if (elapsed >= max_us)
                begin
                    if (pos_inc >= list_len)
                    begin
                        // last channel done: return to idle
                        scanning_next    = 1'b0;
                        pos_next         = '0;
                        dwell_start_next = '0;
                        act_d            = ACT_DONE;
                    end
                    else
                    begin
                        pos_next         = POS_W'(pos_inc);
                        dwell_start_next = now_t;
                        act_d            = ACT_TUNE;
                        base_d           = now_t;
                        tu_d             = active_scan_reg ? probe_delay_tu_reg
                                                           : min_dwell_tu_reg;
                        tbl_re           = accept;
                        tbl_raddr        = pos_inc[AW-1:0];
                    end
                end
                else if (elapsed >= min_us)
                begin
                    act_d = ACT_ARM;
                    tu_d  = max_dwell_tu_reg;
                end
                else if (active_scan_reg && elapsed >= probe_us)
                begin
                    act_d = ACT_PROBE;
                    tu_d  = min_dwell_tu_reg;
                end
                else
                begin
                    act_d = ACT_NONE;
                end
            end
            REQ_ABORT:
            begin
                scanning_next    = 1'b0;
                pos_next         = '0;
                dwell_start_next = '0;
                act_d            = ACT_DONE;
                code_d           = RC_NOT_SUPPORTED;
            end
            default:
            begin
                act_d = ACT_NONE;
            end
        endcase
    end

    wcss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHANNELS)
    ) u_channel_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (req.entry_channel),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg    <= 1'b0;
            pos_reg         <= '0;
            dwell_start_reg <= '0;
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                scanning_reg    <= scanning_next;
                pos_reg         <= pos_next;
                dwell_start_reg <= dwell_start_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Deadline stage: base time plus dwell, then result register
    // ------------------------------------------------------------------
    wcss_action_t s1_act_reg;
    wcss_code_t   s1_code_reg;
    logic [TW-1:0] s1_base_reg;
    logic [15:0]  s1_tu_reg;
    logic [TW-1:0] s1_sum;
    wcss_out_t    rsp_next;
    wcss_out_t    rsp_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg  <= act_d;
            s1_code_reg <= code_d;
            s1_base_reg <= base_d;
            s1_tu_reg   <= tu_d;
        end
        if (out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign s1_sum = s1_base_reg + TW'({s1_tu_reg, 10'b0});

    always_comb
    begin
        rsp_next.action       = s1_act_reg;
        rsp_next.status       = s1_code_reg;
        rsp_next.tune_channel = (s1_act_reg == ACT_TUNE) ? tbl_rdata : 8'd0;
        // a deadline only goes out with an arming action
        if (s1_act_reg == ACT_TUNE || s1_act_reg == ACT_ARM || s1_act_reg == ACT_PROBE)
        begin
            rsp_next.deadline_us = 48'(s1_sum);
        end
        else
        begin
            rsp_next.deadline_us = '0;
        end
    end

    assign rsp = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WCSS_ASSERT(a_stall_needs_full_stage, !req_stall || s1_valid_reg,
        "input stalled with an empty decision stage")
    `WCSS_ASSERT(a_pos_in_list, !scanning_reg || (LEN_W'(pos_reg) < list_len),
        "channel position beyond the scan list while scanning")
    `WCSS_ASSERT_NEXT(a_abort_goes_idle, accept && req.req_type == REQ_ABORT,
        !scanning_reg && pos_reg == '0, "abort did not return the sequencer to idle")
    `WCSS_ASSERT(a_channel_only_on_tune,
        !rsp_valid || rsp.action == ACT_TUNE || rsp.tune_channel == 8'd0,
        "tune channel set on a result that does not tune")

endmodule
